>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bcs_pkg.sv
// Types, sizes and the divide-by-taps function of the boxcar curve smoother.
`default_nettype none
package bcs_pkg;

   // Filter and frame shape
   localparam int TAPS      = 11;
   localparam int BANDS     = 10;
   localparam int FRAME_LEN = 124;

   // Clamp limits of a curve point
   localparam int CURVE_MAX = 9;
   localparam int CURVE_MIN = -8;

   // Field widths of the request and response
   localparam int GAIN_W  = 8;
   localparam int CURVE_W = 5;
   localparam int IDX_W   = 7;

   // Sample and running sum widths inside a cell
   localparam int SAMPLE_W = GAIN_W;
   localparam int SUM_W    = SAMPLE_W + $clog2(TAPS);
   localparam int HIST_LEN = TAPS - 1;

   // Position counter covers the frame and every band start
   localparam int SPAN     = (BANDS * TAPS > FRAME_LEN) ? BANDS * TAPS : FRAME_LEN;
   localparam int POS_W    = $clog2(SPAN + 1);
   localparam int BAND_W   = $clog2(BANDS);

   // Reciprocal multiply for an exact divide by TAPS of a SUM_W-bit magnitude
   localparam int      DIV_SHIFT = SUM_W + $clog2(TAPS);
   localparam longint  DIV_MUL   = ((64'd1 << DIV_SHIFT) + TAPS - 1) / TAPS;
   localparam int      PROD_W    = 2 * SUM_W + 1;

   // Index of the last curve point of a frame
   localparam int LAST_IDX = FRAME_LEN - 1 - TAPS;

   localparam logic signed [SAMPLE_W-1:0] CLAMP_HI = SAMPLE_W'(CURVE_MAX);
   localparam logic signed [SAMPLE_W-1:0] CLAMP_LO = SAMPLE_W'(CURVE_MIN);
   localparam logic signed [CURVE_W-1:0]  CURVE_HI = CURVE_W'(CURVE_MAX);
   localparam logic signed [CURVE_W-1:0]  CURVE_LO = CURVE_W'(CURVE_MIN);

   // Tag that travels with each frame sample along the chain
   typedef struct packed {
      logic             clear;
      logic [POS_W-1:0] pos;
   } tag_type;

   // One sample handed from a cell to its neighbor
   typedef struct packed {
      logic                       valid;
      tag_type                    tag;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_bus_type;

   // Divide a signed window sum by TAPS, truncating toward zero
   function automatic logic signed [SAMPLE_W-1:0] div_taps(
      input logic signed [SUM_W-1:0] sum
   );
      logic [SUM_W-1:0]    mag;
      logic [PROD_W-1:0]   prod;
      logic [SAMPLE_W-1:0] qmag;
      mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(DIV_MUL[SUM_W:0]);
      qmag = prod[DIV_SHIFT +: SAMPLE_W];
      return sum[SUM_W-1] ? SAMPLE_W'(-qmag) : qmag;
   endfunction

endpackage
`default_nettype wire

>>> src/bcs_req_if.sv
// Request channel: one band gain per request.
`default_nettype none
interface bcs_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [bcs_pkg::GAIN_W-1:0] band_gain;

   modport source (output valid, output band_gain, input ready);
   modport sink   (input valid, input band_gain, output ready);
endinterface
`default_nettype wire

>>> src/bcs_rsp_if.sv
// Response channel: one curve point per handshake.
`default_nettype none
interface bcs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bcs_pkg::CURVE_W-1:0] curve_value;
   logic [bcs_pkg::IDX_W-1:0]          curve_index;
   logic                               last_point;

   modport source (output valid, output curve_value, output curve_index,
                   output last_point, input ready);
   modport sink   (input valid, input curve_value, input curve_index,
                   input last_point, output ready);
endinterface
`default_nettype wire

>>> src/bcs_sequencer.sv
// Sequencer: expands each band gain into its run of zero-stuffed frame samples.
`default_nettype none
module bcs_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   bcs_req_if.sink               req_chan,
   input  logic                  advance,
   output bcs_pkg::cell_bus_type issue
);

   logic                              busy_ff, busy_in;
   logic                              first_ff, first_in;
   logic [bcs_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [bcs_pkg::POS_W-1:0]         end_ff, end_in;
   logic [bcs_pkg::POS_W-1:0]         start_ff, start_in;
   logic [bcs_pkg::BAND_W-1:0]        band_ff, band_in;
   logic signed [bcs_pkg::GAIN_W-1:0] gain_ff, gain_in;

   logic                      accept;
   logic                      final_step;
   logic                      last_band;
   logic [bcs_pkg::POS_W-1:0] start_pos;
   logic [bcs_pkg::POS_W-1:0] cand_end;
   logic [bcs_pkg::POS_W-1:0] band_end;
   logic [bcs_pkg::POS_W-1:0] pos_next;

   // Take a request when idle or on the last sample of the current band, never in reset
   always_comb begin
      pos_next   = pos_ff + bcs_pkg::POS_W'(1);
      final_step = busy_ff && advance && (pos_next == end_ff);
      req_chan.ready = !reset && (!busy_ff || final_step);
      accept     = req_chan.valid && req_chan.ready;
   end

   // Work out the sample span of the band being taken
   always_comb begin
      last_band = (band_ff == bcs_pkg::BAND_W'(bcs_pkg::BANDS - 1));
      start_pos = (band_ff == '0) ? '0 : start_ff;
      cand_end  = start_pos + bcs_pkg::POS_W'(bcs_pkg::TAPS);
      if (last_band || (cand_end > bcs_pkg::POS_W'(bcs_pkg::FRAME_LEN))) begin
         band_end = bcs_pkg::POS_W'(bcs_pkg::FRAME_LEN);
      end else begin
         band_end = cand_end;
      end
   end

   // Next state: load a new band, step through the current one, or hold
   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      start_in = start_ff;
      band_in  = band_ff;
      gain_in  = gain_ff;
      priority if (accept) begin
         busy_in  = (start_pos < band_end);
         first_in = 1'b1;
         pos_in   = start_pos;
         end_in   = band_end;
         gain_in  = req_chan.band_gain;
         start_in = last_band ? '0 : cand_end;
         band_in  = last_band ? '0 : band_ff + bcs_pkg::BAND_W'(1);
      end else if (busy_ff && advance) begin
         busy_in  = !final_step;
         first_in = 1'b0;
         pos_in   = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         band_ff  <= '0;
         start_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         band_ff  <= band_in;
         start_ff <= start_in;
      end
      first_ff <= first_in;
      pos_ff   <= pos_in;
      end_ff   <= end_in;
      gain_ff  <= gain_in;
   end

   // Drive the current sample: the gain on the band's first slot, zero elsewhere
   always_comb begin
      issue.valid     = busy_ff;
      issue.tag.clear = (pos_ff == '0);
      issue.tag.pos   = pos_ff;
      issue.sample    = first_ff ? gain_ff : '0;
   end

endmodule
`default_nettype wire

>>> src/bcs_boxcar_cell.sv
// Boxcar cell: one moving-sum stage with its history and divide by taps.
`default_nettype none
module bcs_boxcar_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  bcs_pkg::cell_bus_type up,
   output bcs_pkg::cell_bus_type down
);

   logic signed [bcs_pkg::SAMPLE_W-1:0] hist_ff [bcs_pkg::HIST_LEN];
   logic signed [bcs_pkg::SAMPLE_W-1:0] hist_in [bcs_pkg::HIST_LEN];
   logic signed [bcs_pkg::SUM_W-1:0]    sum_ff, sum_in;
   bcs_pkg::cell_bus_type               down_ff, down_in;

   logic signed [bcs_pkg::SUM_W-1:0]    prior;
   logic signed [bcs_pkg::SUM_W-1:0]    window;
   logic signed [bcs_pkg::SAMPLE_W-1:0] oldest;
   logic                                step;

   // Window sum: new sample plus running sum of the history, zero on frame start
   always_comb begin
      step   = advance && up.valid;
      prior  = up.tag.clear ? '0 : sum_ff;
      oldest = up.tag.clear ? '0 : hist_ff[bcs_pkg::HIST_LEN-1];
      window = prior + bcs_pkg::SUM_W'(up.sample);
      sum_in = window - bcs_pkg::SUM_W'(oldest);
   end

   // Shift the history, dropping the oldest sample
   always_comb begin
      hist_in[0] = up.sample;
      for (int k = 1; k < bcs_pkg::HIST_LEN; k++) begin
         hist_in[k] = up.tag.clear ? '0 : hist_ff[k-1];
      end
   end

   // Hand the averaged sample to the next cell
   always_comb begin
      down_in.valid  = up.valid;
      down_in.tag    = up.tag;
      down_in.sample = bcs_pkg::div_taps(window);
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hist_ff <= hist_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (advance) begin
         down_ff.valid <= down_in.valid;
      end
      if (advance) begin
         down_ff.tag    <= down_in.tag;
         down_ff.sample <= down_in.sample;
      end
   end

   assign down = down_ff;

endmodule
`default_nettype wire

>>> src/cascaded_boxcar_curve_smoother.sv
// Top level: sequencer, chain of three boxcar cells and clamped output register.
// A frame sample passes the register of each cell and the output register.
// Throughput: the sequencer issues one frame sample per cycle while responses are
// not stalled; a band is TAPS (11) samples, the last FRAME_LEN-(BANDS-1)*TAPS (25).
// A request is taken while the previous band's last sample issues, with no gap.
// Synchronous reset clears the band counter and all valid bits; histories clear
// themselves on the first sample of every frame.
`default_nettype none
module cascaded_boxcar_curve_smoother (
   input  logic      clock,
   input  logic      reset,
   bcs_req_if.sink   req_chan,
   bcs_rsp_if.source rsp_chan
);

   bcs_pkg::cell_bus_type stage_bus [4];

   logic                                out_valid_ff, out_valid_in;
   logic signed [bcs_pkg::CURVE_W-1:0]  out_value_ff, out_value_in;
   logic [bcs_pkg::IDX_W-1:0]           out_index_ff, out_index_in;
   logic                                out_last_ff, out_last_in;
   logic                                advance;
   logic signed [bcs_pkg::SAMPLE_W-1:0] y;
   logic [bcs_pkg::POS_W-1:0]           idx_full;

   // Move the whole chain whenever the output register can take a point
   assign advance = !out_valid_ff || rsp_chan.ready;

   bcs_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .issue    (stage_bus[0])
   );

   for (genvar g = 0; g < 3; g++) begin : g_cell
      bcs_boxcar_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up      (stage_bus[g]),
         .down    (stage_bus[g+1])
      );
   end

   // Clamp the smoothed value and drop positions before the first tap span
   always_comb begin
      y        = stage_bus[3].sample;
      idx_full = stage_bus[3].tag.pos - bcs_pkg::POS_W'(bcs_pkg::TAPS);
      out_valid_in = stage_bus[3].valid
                  && (stage_bus[3].tag.pos >= bcs_pkg::POS_W'(bcs_pkg::TAPS));
      priority if (y > bcs_pkg::CLAMP_HI) begin
         out_value_in = bcs_pkg::CURVE_HI;
      end else if (y < bcs_pkg::CLAMP_LO) begin
         out_value_in = bcs_pkg::CURVE_LO;
      end else begin
         out_value_in = y[bcs_pkg::CURVE_W-1:0];
      end
      out_index_in = idx_full[bcs_pkg::IDX_W-1:0];
      out_last_in  = (stage_bus[3].tag.pos == bcs_pkg::POS_W'(bcs_pkg::FRAME_LEN - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_value_ff <= out_value_in;
         out_index_ff <= out_index_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.curve_value = out_value_ff;
   assign rsp_chan.curve_index = out_index_ff;
   assign rsp_chan.last_point  = out_last_ff;

endmodule
`default_nettype wire

>>> src/bcs_checker.sv
// Port checker for the boxcar curve smoother, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bcs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [bcs_pkg::CURVE_W-1:0] curve_value,
   input logic [bcs_pkg::IDX_W-1:0]          curve_index,
   input logic                               last_point
);

   logic [bcs_pkg::IDX_W-1:0] next_idx_ff, next_idx_in;
   logic                      value_in_range;
   logic                      index_in_order;
   logic                      last_at_end;

   // Track the index the next curve point must carry
   always_comb begin
      next_idx_in = next_idx_ff;
      if (rsp_valid && rsp_ready) begin
         next_idx_in = last_point ? '0 : curve_index + bcs_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_idx_ff <= '0;
      end else begin
         next_idx_ff <= next_idx_in;
      end
   end

   // Compare the visible response against range, order and frame end
   always_comb begin
      value_in_range = (curve_value <= bcs_pkg::CURVE_HI)
                    && (curve_value >= bcs_pkg::CURVE_LO);
      index_in_order = (curve_index == next_idx_ff);
      last_at_end    = (curve_index == bcs_pkg::IDX_W'(bcs_pkg::LAST_IDX));
   end

   // Check stall hold, clamped values, index order and the last index
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `ASSERT_ALWAYS(a_value_range, clock, rsp_valid |-> value_in_range, "value out of range")
   `ASSERT_CLK(a_index_order, clock, reset, rsp_valid |-> index_in_order, "index out of order")
   `ASSERT_CLK(a_last_index, clock, reset, rsp_valid && last_point |-> last_at_end, "bad last index")

endmodule

bind cascaded_boxcar_curve_smoother bcs_checker u_bcs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .curve_value (rsp_chan.curve_value),
   .curve_index (rsp_chan.curve_index),
   .last_point  (rsp_chan.last_point)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the cascaded boxcar curve smoother.
`default_nettype none
module testbench;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 12;
   localparam int RANDOM_GAINS = 225;

   typedef struct {
      logic signed [bcs_pkg::CURVE_W-1:0] value;
      logic [bcs_pkg::IDX_W-1:0]          index;
      logic                               last;
   } curve_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcs_req_if req_chan ();
   bcs_rsp_if rsp_chan ();

   cascaded_boxcar_curve_smoother dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Stimulus and expected results
   logic signed [bcs_pkg::GAIN_W-1:0] gain_queue[$];
   curve_point_type                   expected_points[$];
   curve_point_type                   seen_point;

   // Smoother state as the predictor sees it
   int window_hist[3][bcs_pkg::HIST_LEN];
   int next_band;

   int error_count;
   int gains_taken;
   int points_checked;
   int frames_closed;
   int idle_cycles;

   // Driver state
   bit offer_active;
   int gains_sent;
   int burst_left;
   int gap_left;

   // Receiver state
   int stall_mode;
   int stall_phase;

   // One moving-sum stage: sum the window, shift in the sample, divide toward zero
   function automatic int boxcar_stage(input int s, input int x);
      int sum;
      sum = x;
      for (int k = 0; k < bcs_pkg::HIST_LEN; k++) sum += window_hist[s][k];
      for (int k = bcs_pkg::HIST_LEN - 1; k > 0; k--) window_hist[s][k] = window_hist[s][k-1];
      window_hist[s][0] = x;
      return sum / bcs_pkg::TAPS;
   endfunction

   // Expand one band gain over its frame positions and queue the curve points
   function automatic void predict_band(input logic signed [bcs_pkg::GAIN_W-1:0] gain);
      int band;
      int first_pos;
      int stop_pos;
      int y;
      curve_point_type pt;
      band = (next_band >= bcs_pkg::BANDS) ? 0 : next_band;
      if (band == 0) begin
         for (int s = 0; s < 3; s++)
            for (int k = 0; k < bcs_pkg::HIST_LEN; k++) window_hist[s][k] = 0;
      end
      first_pos = band * bcs_pkg::TAPS;
      stop_pos  = (band + 1 >= bcs_pkg::BANDS) ? bcs_pkg::FRAME_LEN
                                              : first_pos + bcs_pkg::TAPS;
      if (stop_pos > bcs_pkg::FRAME_LEN) stop_pos = bcs_pkg::FRAME_LEN;
      for (int pos = first_pos; pos < stop_pos; pos++) begin
         y = boxcar_stage(0, (pos == first_pos) ? int'(gain) : 0);
         y = boxcar_stage(1, y);
         y = boxcar_stage(2, y);
         if (pos >= bcs_pkg::TAPS) begin
            if (y > bcs_pkg::CURVE_MAX) y = bcs_pkg::CURVE_MAX;
            if (y < bcs_pkg::CURVE_MIN) y = bcs_pkg::CURVE_MIN;
            pt.value = bcs_pkg::CURVE_W'(y);
            pt.index = bcs_pkg::IDX_W'(pos - bcs_pkg::TAPS);
            pt.last  = (pos == bcs_pkg::FRAME_LEN - 1);
            expected_points.push_back(pt);
         end
      end
      next_band = (band + 1 >= bcs_pkg::BANDS) ? 0 : band + 1;
   endfunction

   // Pick the next burst length and the gap that follows it
   function automatic void plan_burst();
      if ($urandom_range(3) == 0) begin
         burst_left = $urandom_range(60, 30);
         gap_left   = 0;
      end else begin
         burst_left = $urandom_range(20, 1);
         gap_left   = $urandom_range(15);
      end
   endfunction

   // Drive band gains at the falling edge in bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         offer_active = 0;
      end else begin
         // Drop the offer once the monitor has counted it as taken
         if (offer_active && gains_taken == gains_sent) offer_active = 0;
         if (!offer_active) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (gain_queue.size() > 0) begin
               req_chan.valid     <= 1'b1;
               req_chan.band_gain <= gain_queue.pop_front();
               offer_active = 1;
               gains_sent++;
               burst_left--;
               if (burst_left <= 0) plan_burst();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Stall the response channel on a pattern that changes mode now and then
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(3);
      case (stall_mode)
         0: begin
            rsp_chan.ready <= 1'b1;
         end
         1: begin
            rsp_chan.ready <= ($urandom_range(3) != 0);
         end
         2: begin
            rsp_chan.ready <= (stall_phase % 7 >= 3);
         end
         default: begin
            rsp_chan.ready <= ($urandom_range(3) == 0);
         end
      endcase
   end

   // Predict on each accepted request and check each accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_band(req_chan.band_gain);
            gains_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected curve point: value %0d index %0d last %0b",
                      rsp_chan.curve_value, rsp_chan.curve_index, rsp_chan.last_point);
               error_count++;
            end else begin
               seen_point = expected_points.pop_front();
               if (rsp_chan.curve_value !== seen_point.value) begin
                  $error("curve_value: expected %0d, actual %0d",
                         seen_point.value, rsp_chan.curve_value);
                  error_count++;
               end
               if (rsp_chan.curve_index !== seen_point.index) begin
                  $error("curve_index: expected %0d, actual %0d",
                         seen_point.index, rsp_chan.curve_index);
                  error_count++;
               end
               if (rsp_chan.last_point !== seen_point.last) begin
                  $error("last_point: expected %0b, actual %0b",
                         seen_point.last, rsp_chan.last_point);
                  error_count++;
               end
               if (seen_point.last) frames_closed++;
               points_checked++;
            end
         end
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      // Directed: a frame at the positive extreme, one at the negative extreme,
      // then nominal limits, zero and the smallest steps
      repeat (bcs_pkg::BANDS) gain_queue.push_back(8'sd127);
      repeat (bcs_pkg::BANDS) gain_queue.push_back(-8'sd128);
      gain_queue.push_back(8'sd100);
      gain_queue.push_back(-8'sd100);
      gain_queue.push_back(8'sd0);
      gain_queue.push_back(8'sd1);
      gain_queue.push_back(-8'sd1);

      // Random: mostly nominal gains, some raw 8-bit patterns and extremes
      for (int i = 0; i < RANDOM_GAINS; i++) begin
         case ($urandom_range(19))
            0, 1, 2: gain_queue.push_back(bcs_pkg::GAIN_W'($urandom));
            3, 4: begin
               case ($urandom_range(4))
                  0: gain_queue.push_back(8'sd127);
                  1: gain_queue.push_back(-8'sd128);
                  2: gain_queue.push_back(8'sd100);
                  3: gain_queue.push_back(-8'sd100);
                  default: gain_queue.push_back(8'sd0);
               endcase
            end
            default: gain_queue.push_back(
                        bcs_pkg::GAIN_W'(int'($urandom_range(200)) - 100));
         endcase
      end

      // Hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for all gains to go in and all curve points to come out
      do @(posedge clock);
      while (gain_queue.size() != 0 || offer_active || expected_points.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d band gains, %0d curve points checked, %0d full frames",
               gains_taken, points_checked, frames_closed);
      $display("with random sender gaps and response stalls");
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

>>> cascaded_boxcar_curve_smoother.f
+incdir+src
src/bcs_pkg.sv
src/bcs_req_if.sv
src/bcs_rsp_if.sv
src/bcs_sequencer.sv
src/bcs_boxcar_cell.sv
src/cascaded_boxcar_curve_smoother.sv
src/bcs_checker.sv
tb/testbench.sv
